[rtl/core/nat_pkg.sv]
// nat_pkg: shared types, constants and helpers for the node activity table
// depends on nothing; used by nat_ctrl, nat_dp and node_activity_table_core
`default_nettype none
package nat_pkg;
  localparam int DefDeviceSlots   = 16;
  localparam int DefObservedSlots = 16;
  localparam logic [15:0] PosFull   = 16'hC800;
  localparam logic [15:0] FramesMax = 16'hFFFF;
  localparam logic [7:0]  UnknownPct = 8'hFF;

  localparam logic [2:0] FnAdd      = 3'd0;
  localparam logic [2:0] FnRemove   = 3'd1;
  localparam logic [2:0] FnFrame    = 3'd2;
  localparam logic [2:0] FnPosition = 3'd3;
  localparam logic [2:0] FnError    = 3'd4;
  localparam logic [2:0] FnCommand  = 3'd5;
  localparam logic [2:0] FnSettled  = 3'd6;
  localparam logic [2:0] FnClearObs = 3'd7;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StNoReg = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture transaction
    logic scan_clr;   // restart scan index
    logic scan_dev;   // step device scan
    logic scan_obs;   // step observed scan
    logic apply;      // perform update
    logic finish;     // load result register
  } nat_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic dev_last;
    logic obs_last;
    logic out_busy;
  } nat_sts_t;

  // 100 - raw*100/0xC800 for raw <= 0xC800; raw*100/51200 == raw/512
  function automatic logic [7:0] to_percent(input logic [15:0] raw);
    logic [7:0] q;
    begin
      q = {1'b0, raw[15:9]};
      if (raw > PosFull) to_percent = UnknownPct;
      else to_percent = 8'd100 - q;
    end
  endfunction
endpackage
`default_nettype wire

[rtl/core/nat_ctrl.sv]
// nat_ctrl: sequencing state machine of the node activity table
// depends on nat_pkg
`default_nettype none
module nat_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_take,
  input  wire nat_pkg::nat_sts_t sts,
  output nat_pkg::nat_cmd_t    cmd,
  output logic                 idle
);
  import nat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEV   = 5'b00010,
    S_OBS   = 5'b00100,
    S_APPLY = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_take) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = S_DEV;
        end
      end
      S_DEV: begin
        cmd.scan_dev = 1'b1;
        if (sts.dev_last) begin
          cmd.scan_clr = 1'b1;
          state_next = S_OBS;
        end
      end
      S_OBS: begin
        cmd.scan_obs = 1'b1;
        if (sts.obs_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE) else $error("finish did not return idle");
  a_apply_once: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> !cmd.apply) else $error("apply repeated");
endmodule
`default_nettype wire

[rtl/core/nat_dp.sv]
// nat_dp: device and observed tables, scan units and result register
// depends on nat_pkg
`default_nettype none
module nat_dp #(
  parameter int DEVICE_SLOTS   = nat_pkg::DefDeviceSlots,
  parameter int OBSERVED_SLOTS = nat_pkg::DefObservedSlots
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nat_pkg::nat_cmd_t cmd,
  output nat_pkg::nat_sts_t      sts,
  input  wire logic [2:0]        func,
  input  wire logic [23:0]       node,
  input  wire logic [31:0]       now_ms,
  input  wire logic [7:0]        command_code,
  input  wire logic signed [7:0] signal_dbm,
  input  wire logic [15:0]       raw_current,
  input  wire logic [15:0]       raw_target,
  input  wire logic [7:0]        error_code,
  input  wire logic signed [7:0] command_target,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [1:0]             status,
  output logic [3:0]             slot,
  output logic signed [7:0]      position_pct,
  output logic signed [7:0]      target_pct,
  output logic                   is_moving,
  output logic [3:0]             observed_row,
  output logic [15:0]            frame_count
);
  import nat_pkg::*;

  localparam int DW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int OW = (OBSERVED_SLOTS > 1) ? $clog2(OBSERVED_SLOTS) : 1;
  localparam int SW = (DW > OW) ? DW : OW;

  // device table
  logic        d_used [DEVICE_SLOTS];
  logic [23:0] d_node [DEVICE_SLOTS];
  logic [7:0]  d_pos  [DEVICE_SLOTS];
  logic [7:0]  d_tgt  [DEVICE_SLOTS];
  logic        d_mov  [DEVICE_SLOTS];
  logic [31:0] d_seen [DEVICE_SLOTS];
  logic [31:0] d_ptim [DEVICE_SLOTS];
  logic [7:0]  d_sig  [DEVICE_SLOTS];
  logic [7:0]  d_err  [DEVICE_SLOTS];
  // observed table
  logic        o_used [OBSERVED_SLOTS];
  logic [23:0] o_node [OBSERVED_SLOTS];
  logic [31:0] o_seen [OBSERVED_SLOTS];
  logic [15:0] o_frm  [OBSERVED_SLOTS];
  logic [7:0]  o_sig  [OBSERVED_SLOTS];
  logic [7:0]  o_cmd  [OBSERVED_SLOTS];

  // captured transaction
  logic [2:0]  r_func;
  logic [23:0] r_node;
  logic [31:0] r_now;
  logic [7:0]  r_cmd, r_sig, r_err, r_ctgt;
  logic [15:0] r_cur, r_tgt;

  // scan results
  logic [SW-1:0] idx;
  logic          dev_hit, dev_free;
  logic [DW-1:0] dev_i, free_i;
  logic          obs_hit, obs_free, obs_have;
  logic [OW-1:0] obs_i, vic_i;
  logic [31:0]   vic_time;

  logic [DW-1:0] di;
  logic [OW-1:0] oi;
  assign di = idx[DW-1:0];
  assign oi = idx[OW-1:0];

  assign sts.dev_last = (di == DW'(DEVICE_SLOTS - 1));
  assign sts.obs_last = (oi == OW'(OBSERVED_SLOTS - 1));
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= func; r_node <= node; r_now <= now_ms; r_cmd <= command_code;
      r_sig <= signal_dbm; r_cur <= raw_current; r_tgt <= raw_target;
      r_err <= error_code; r_ctgt <= command_target;
      dev_hit <= 1'b0; dev_free <= 1'b0; obs_hit <= 1'b0;
      obs_free <= 1'b0; obs_have <= 1'b0;
    end
    if (cmd.scan_clr) idx <= '0;
    else if (cmd.scan_dev || cmd.scan_obs) idx <= idx + SW'(1);
    if (cmd.scan_dev) begin
      if (!dev_hit && d_used[di] && d_node[di] == r_node) begin
        dev_hit <= 1'b1; dev_i <= di;
      end
      if (!dev_free && !d_used[di]) begin
        dev_free <= 1'b1; free_i <= di;
      end
    end
    if (cmd.scan_obs) begin
      if (!obs_hit && o_used[oi] && o_node[oi] == r_node) begin
        obs_hit <= 1'b1; obs_i <= oi;
      end
      if (!obs_free) begin
        if (!o_used[oi]) begin
          obs_free <= 1'b1; vic_i <= oi;
        end else if (!obs_have || o_seen[oi] < vic_time) begin
          obs_have <= 1'b1; vic_i <= oi; vic_time <= o_seen[oi];
        end
      end
    end
  end

  // update step
  logic [7:0] pc, pt;
  assign pc = to_percent(r_cur);
  assign pt = to_percent(r_tgt);

  logic [1:0]    res_status;
  logic          res_dev;
  logic [DW-1:0] res_slot;
  logic          res_obs;
  logic [OW-1:0] res_row;
  logic [OW-1:0] tgt_row;
  assign tgt_row = obs_hit ? obs_i : vic_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        d_used[i] <= 1'b0; d_node[i] <= '0; d_pos[i] <= UnknownPct;
        d_tgt[i] <= UnknownPct; d_mov[i] <= 1'b0; d_seen[i] <= '0;
        d_ptim[i] <= '0; d_sig[i] <= '0; d_err[i] <= '0;
      end
      for (int i = 0; i < OBSERVED_SLOTS; i++) begin
        o_used[i] <= 1'b0; o_node[i] <= '0; o_seen[i] <= '0;
        o_frm[i] <= '0; o_sig[i] <= '0; o_cmd[i] <= '0;
      end
    end else if (cmd.apply) begin
      res_status <= StDone; res_dev <= 1'b0; res_obs <= 1'b0;
      res_slot <= '0; res_row <= '0;
      if (r_func == FnClearObs) begin
        for (int i = 0; i < OBSERVED_SLOTS; i++) begin
          o_used[i] <= 1'b0; o_node[i] <= '0; o_seen[i] <= '0;
          o_frm[i] <= '0; o_sig[i] <= '0; o_cmd[i] <= '0;
        end
      end else if (r_func == FnAdd) begin
        if (dev_hit) begin
          res_dev <= 1'b1; res_slot <= dev_i;
        end else if (dev_free) begin
          res_dev <= 1'b1; res_slot <= free_i;
          d_used[free_i] <= 1'b1; d_node[free_i] <= r_node;
          d_pos[free_i] <= UnknownPct; d_tgt[free_i] <= UnknownPct;
          d_mov[free_i] <= 1'b0; d_seen[free_i] <= '0; d_ptim[free_i] <= '0;
          d_sig[free_i] <= '0; d_err[free_i] <= '0;
        end else begin
          res_status <= StFull;
        end
      end else if (!dev_hit) begin
        res_status <= StNoReg;
        if (r_func == FnFrame) begin
          res_obs <= 1'b1; res_row <= tgt_row;
          o_seen[tgt_row] <= r_now; o_sig[tgt_row] <= r_sig;
          o_cmd[tgt_row] <= r_cmd;
          if (obs_hit) begin
            if (o_frm[tgt_row] != FramesMax) o_frm[tgt_row] <= o_frm[tgt_row] + 16'd1;
          end else begin
            o_used[tgt_row] <= 1'b1; o_node[tgt_row] <= r_node;
            o_frm[tgt_row] <= 16'd1;
          end
        end
      end else begin
        res_dev <= 1'b1; res_slot <= dev_i;
        case (r_func)
          FnRemove: begin
            d_used[dev_i] <= 1'b0; d_node[dev_i] <= '0; d_pos[dev_i] <= UnknownPct;
            d_tgt[dev_i] <= UnknownPct; d_mov[dev_i] <= 1'b0; d_seen[dev_i] <= '0;
            d_ptim[dev_i] <= '0; d_sig[dev_i] <= '0; d_err[dev_i] <= '0;
          end
          FnFrame: begin
            d_seen[dev_i] <= r_now; d_sig[dev_i] <= r_sig;
          end
          FnPosition: begin
            d_pos[dev_i] <= pc; d_ptim[dev_i] <= r_now; d_seen[dev_i] <= r_now;
            d_err[dev_i] <= '0;
            if (pt != UnknownPct) d_tgt[dev_i] <= pt;
            d_mov[dev_i] <= (pc != UnknownPct) && (pt != UnknownPct) && (pc != pt);
          end
          FnError: begin
            d_err[dev_i] <= r_err; d_mov[dev_i] <= 1'b0; d_seen[dev_i] <= r_now;
          end
          FnCommand: begin
            d_err[dev_i] <= '0; d_tgt[dev_i] <= r_ctgt; d_mov[dev_i] <= !r_ctgt[7];
          end
          default: d_mov[dev_i] <= 1'b0;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.finish) begin
      status       <= res_status;
      slot         <= 4'(res_slot);
      position_pct <= res_dev ? d_pos[res_slot] : UnknownPct;
      target_pct   <= res_dev ? d_tgt[res_slot] : UnknownPct;
      is_moving    <= res_dev ? d_mov[res_slot] : 1'b0;
      observed_row <= 4'(res_row);
      frame_count  <= res_obs ? o_frm[res_row] : 16'd0;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall)) else $error("result overwritten");
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == StDone || status == StNoReg || status == StFull))
    else $error("bad status");
  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == StFull) |-> (slot == 4'd0 && !is_moving))
    else $error("full result with device data");
endmodule
`default_nettype wire

[rtl/core/node_activity_table_core.sv]
// node_activity_table_core: top level of the node activity table
// depends on nat_pkg, nat_ctrl and nat_dp
//
// usage:
//   input channel: in_valid/in_stall carry one transaction (func, node, now_ms and
//   the frame, position, error and command fields); accepted when in_valid is high
//   and in_stall low. one result transaction (status, slot, position_pct,
//   target_pct, is_moving, observed_row, frame_count) leaves per input on
//   out_valid/out_stall.
//   timing: one transaction at a time; the path from accept to out_valid is set by
//   the serial scan of the device table and then the observed table, one entry
//   per cycle, followed by the update step and the result register load. the
//   sequencer is idle again in the cycle that out_valid rises.
//   the next input is taken while the result still waits in the output register;
//   a stalled result holds, and the following result waits until it is taken,
//   with the input stalled meanwhile.
//   reset: synchronous, active high; both tables return to empty at once,
//   positions read as unknown (-1), no result pending, input stalled.
`default_nettype none
module node_activity_table_core #(
  parameter int DEVICE_SLOTS   = nat_pkg::DefDeviceSlots,
  parameter int OBSERVED_SLOTS = nat_pkg::DefObservedSlots
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        func,
  input  wire logic [23:0]       node,
  input  wire logic [31:0]       now_ms,
  input  wire logic [7:0]        command_code,
  input  wire logic signed [7:0] signal_dbm,
  input  wire logic [15:0]       raw_current,
  input  wire logic [15:0]       raw_target,
  input  wire logic [7:0]        error_code,
  input  wire logic signed [7:0] command_target,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [3:0]             slot,
  output logic signed [7:0]      position_pct,
  output logic signed [7:0]      target_pct,
  output logic                   is_moving,
  output logic [3:0]             observed_row,
  output logic [15:0]            frame_count
);
  import nat_pkg::*;

  nat_cmd_t cmd;
  nat_sts_t sts;
  logic     idle;

  // ready only when the sequencer is idle and out of reset
  assign in_stall = rst || !idle;

  nat_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_take(in_valid && !in_stall), .sts(sts), .cmd(cmd),
    .idle(idle)
  );

  nat_dp #(.DEVICE_SLOTS(DEVICE_SLOTS), .OBSERVED_SLOTS(OBSERVED_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .func(func), .node(node), .now_ms(now_ms), .command_code(command_code),
    .signal_dbm(signal_dbm), .raw_current(raw_current), .raw_target(raw_target),
    .error_code(error_code), .command_target(command_target),
    .out_stall(out_stall), .out_valid(out_valid), .status(status), .slot(slot),
    .position_pct(position_pct), .target_pct(target_pct), .is_moving(is_moving),
    .observed_row(observed_row), .frame_count(frame_count)
  );

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> cmd.load) else $error("accept without load");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(slot)))
    else $error("stalled result changed");
endmodule
`default_nettype wire
